FILE: hdl/dda_line_rasterizer_unit_defines.svh
// ----------------------------------------------------------------------------
// dda_line_rasterizer_unit_defines
// assertion macros used by the rasterizer controller
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_RASTERIZER_UNIT_DEFINES_SVH
`define DDA_LINE_RASTERIZER_UNIT_DEFINES_SVH

// same-cycle implication, clocked by aclk, off during reset
`define DLR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked by aclk, off during reset
`define DLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// constants and controller/datapath signal groups of the line rasterizer
// ----------------------------------------------------------------------------
package dlr_pkg;

    localparam int TILE_SIZE = 64;
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = $clog2(TILE_SIZE);
    localparam int STEP_W    = COORD_W;
    localparam int LEFT_W    = COORD_W + 1;
    localparam int QUO_W     = COORD_W + FRAC_BITS;
    localparam int ACC_W     = COORD_W + FRAC_BITS + 2;
    localparam int CNT_W     = $clog2(QUO_W);
    localparam int REG_W     = 7;
    localparam int REG_MAX   = 64;
    localparam int IDX_W     = 12;
    localparam int COLOR_W   = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_y;
        logic store_x;
        logic store_y;
        logic step;
    } dlr_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic last;
        logic out_free;
    } dlr_sts_t;

endpackage

FILE: hdl/dlr_div.sv
// ----------------------------------------------------------------------------
// dlr_div
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dlr_div
    import dlr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [QUO_W-1:0]  dividend,
    input  logic [STEP_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [QUO_W-1:0]  quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [STEP_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W:0]   rem_sh;
    logic              fits;

    always_comb begin
        rem_sh    = {rem_reg, quo_reg[QUO_W-1]};
        fits      = rem_sh >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUO_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = fits ? STEP_W'(rem_sh - {1'b0, divisor}) : rem_sh[STEP_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hdl/dlr_dp.sv
// ----------------------------------------------------------------------------
// dlr_dp
// rasterizer datapath: screen registers, line setup, increment division,
// fixed-point accumulators and the output word register
// ----------------------------------------------------------------------------
module dlr_dp
    import dlr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dlr_cmd_t             cmd,
    output dlr_sts_t             sts,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  logic [COORD_W-1:0]   start_x,
    input  logic [COORD_W-1:0]   start_y,
    input  logic [COORD_W-1:0]   end_x,
    input  logic [COORD_W-1:0]   end_y,
    input  logic [COLOR_W-1:0]   line_color,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [COORD_W-1:0]   pixel_x,
    output logic [COORD_W-1:0]   pixel_y,
    output logic [IDX_W-1:0]     buffer_index,
    output logic [COLOR_W-1:0]   pixel_color,
    output logic                 write_enable,
    output logic                 last_pixel
);

    function automatic logic [REG_W-1:0] sat_reg(input logic [REG_W-1:0] v);
        return (v > REG_W'(REG_MAX)) ? REG_W'(REG_MAX) : v;
    endfunction

    function automatic logic [COORD_W-1:0] pos_of(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0]           s;
        logic [ACC_W-FRAC_BITS-1:0] r;
        s = ACC_W'(unsigned'(v)) + ACC_W'(1 << (FRAC_BITS - 1));
        r = s[ACC_W-1:FRAC_BITS];
        if (v[ACC_W-1])
            return '0;
        else if (r > (ACC_W-FRAC_BITS)'(TILE_SIZE - 1))
            return COORD_W'(TILE_SIZE - 1);
        else
            return r[COORD_W-1:0];
    endfunction

    logic [REG_W-1:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= REG_W'(REG_MAX);
            height_reg <= REG_W'(REG_MAX);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  width_reg  <= sat_reg(cfg_data);
                CFG_SCREEN_HEIGHT: height_reg <= sat_reg(cfg_data);
                default: ;
            endcase
        end
    end

    // line setup
    logic signed [COORD_W:0] dx, dy;
    logic [STEP_W-1:0]       adx, ady, steps;

    always_comb begin
        dx    = signed'({1'b0, end_x}) - signed'({1'b0, start_x});
        dy    = signed'({1'b0, end_y}) - signed'({1'b0, start_y});
        adx   = dx[COORD_W] ? STEP_W'(-dx) : STEP_W'(dx);
        ady   = dy[COORD_W] ? STEP_W'(-dy) : STEP_W'(dy);
        steps = (adx >= ady) ? adx : ady;
    end

    logic [STEP_W-1:0]        adx_reg, ady_reg, steps_reg;
    logic                     neg_x_reg, neg_y_reg;
    logic [COLOR_W-1:0]       color_reg;
    logic signed [ACC_W-1:0]  acc_x_reg, acc_y_reg, inc_x_reg, inc_y_reg;
    logic [LEFT_W-1:0]        left_reg;

    // increment division
    logic [QUO_W-1:0]        div_dividend, div_quo;
    logic                    div_busy, div_done;
    logic signed [ACC_W-1:0] inc_val;
    logic                    inc_neg;

    always_comb begin
        div_dividend = {(cmd.div_y ? ady_reg : adx_reg), {FRAC_BITS{1'b0}}}
                       + QUO_W'(steps_reg[STEP_W-1:1]);
        inc_neg      = cmd.store_y ? neg_y_reg : neg_x_reg;
        if (steps_reg == '0)
            inc_val = '0;
        else if (inc_neg)
            inc_val = -signed'(ACC_W'(div_quo));
        else
            inc_val = signed'(ACC_W'(div_quo));
    end

    dlr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (steps_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else if (cmd.load) begin
            left_reg <= LEFT_W'(steps) + 1'b1;
        end else if (cmd.step) begin
            left_reg <= left_reg - 1'b1;
        end
        if (cmd.load) begin
            adx_reg   <= adx;
            ady_reg   <= ady;
            steps_reg <= steps;
            neg_x_reg <= dx[COORD_W];
            neg_y_reg <= dy[COORD_W];
            color_reg <= line_color;
            acc_x_reg <= signed'(ACC_W'({start_x, {FRAC_BITS{1'b0}}}));
            acc_y_reg <= signed'(ACC_W'({start_y, {FRAC_BITS{1'b0}}}));
        end else if (cmd.step) begin
            acc_x_reg <= acc_x_reg + inc_x_reg;
            acc_y_reg <= acc_y_reg + inc_y_reg;
        end
        if (cmd.store_x)
            inc_x_reg <= inc_val;
        if (cmd.store_y)
            inc_y_reg <= inc_val;
    end

    // pixel of the current step
    logic [COORD_W-1:0] px, py;
    logic [IDX_W:0]     idx_full;

    always_comb begin
        px       = pos_of(acc_x_reg);
        py       = pos_of(acc_y_reg);
        idx_full = (IDX_W+1)'(py) * (IDX_W+1)'(width_reg) + (IDX_W+1)'(px);
    end

    logic                 m_tvalid_reg;
    logic [COORD_W-1:0]   pixel_x_reg, pixel_y_reg;
    logic [IDX_W-1:0]     index_reg;
    logic [COLOR_W-1:0]   pix_color_reg;
    logic                 we_reg, last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.step) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.step) begin
            pixel_x_reg   <= px;
            pixel_y_reg   <= py;
            index_reg     <= idx_full[IDX_W-1:0];
            pix_color_reg <= color_reg;
            we_reg        <= ({1'b0, px} < width_reg) && ({1'b0, py} < height_reg);
            last_reg      <= left_reg == LEFT_W'(1);
        end
    end

    assign sts.div_busy = div_busy;
    assign sts.div_done = div_done;
    assign sts.last     = left_reg == LEFT_W'(1);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid     = m_tvalid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign buffer_index = index_reg;
    assign pixel_color  = pix_color_reg;
    assign write_enable = we_reg;
    assign last_pixel   = last_reg;

endmodule

FILE: hdl/dlr_ctrl.sv
// ----------------------------------------------------------------------------
// dlr_ctrl
// rasterizer controller: accepts a line, sequences the two increment
// divisions, then steps the accumulators one pixel per free output slot
// ----------------------------------------------------------------------------
`include "dda_line_rasterizer_unit_defines.svh"

module dlr_ctrl
    import dlr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output dlr_cmd_t cmd,
    input  dlr_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV_X,
        ST_DIV_Y,
        ST_DRAW
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = state_reg == ST_IDLE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_X;
            end
            ST_DIV_X: begin
                if (sts.div_done) begin
                    cmd.store_x   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_y     = 1'b1;
                    state_next    = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (sts.div_done) begin
                    cmd.store_y = 1'b1;
                    state_next  = ST_DRAW;
                end
            end
            ST_DRAW: begin
                if (sts.out_free) begin
                    cmd.step = 1'b1;
                    if (sts.last)
                        state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `DLR_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_reg == ST_START, "accepted line did not start setup")
    `DLR_ASSERT_NOW(a_done_in_div, sts.div_done, state_reg == ST_DIV_X || state_reg == ST_DIV_Y, "divider finished outside division")
    `DLR_ASSERT_NOW(a_draw_div_idle, state_reg == ST_DRAW, !sts.div_busy, "divider busy while drawing")
    `DLR_ASSERT_NEXT(a_last_ends, cmd.step && sts.last, state_reg == ST_IDLE, "line did not end after last pixel")

endmodule

FILE: hdl/dda_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer_unit
// DDA line rasterizer: one line word in, one pixel word per step out
// ----------------------------------------------------------------------------
// A line word is taken while the unit is idle (s_tready high). Setup then
// runs the shared one-bit-per-cycle divider, which forms the x and then the
// y increment (22 quotient bits each). After that the accumulators give one
// pixel word per cycle for max(|dx|,|dy|) + 1 pixels, slowed only by
// m_tready, and s_tready returns as the last pixel enters the output
// register. The user must write screen width and height through the cfg
// port between lines; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_unit
    import dlr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // start_x, start_y, end_x, end_y, line_color
    input  logic [55:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pixel_x, pixel_y, buffer_index, pixel_color
    output logic [55:0]          m_tdata,
    // write_enable
    output logic                 m_tuser,
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data
);

    dlr_cmd_t           cmd;
    dlr_sts_t           sts;
    logic [COORD_W-1:0] pixel_x, pixel_y;
    logic [IDX_W-1:0]   buffer_index;
    logic [COLOR_W-1:0] pixel_color;

    assign cfg_ready = 1'b1;

    dlr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    dlr_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start_x      (s_tdata[5:0]),
        .start_y      (s_tdata[11:6]),
        .end_x        (s_tdata[17:12]),
        .end_y        (s_tdata[23:18]),
        .line_color   (s_tdata[55:24]),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .buffer_index (buffer_index),
        .pixel_color  (pixel_color),
        .write_enable (m_tuser),
        .last_pixel   (m_tlast)
    );

    assign m_tdata = {pixel_color, buffer_index, pixel_y, pixel_x};

endmodule
